@@ design/lzht_pkg.sv @@
// shared types and constants for the layer z-order hit test unit
`timescale 1ns / 1ps
package lzht_pkg;

  localparam int MaxLayers = 16;
  localparam int IdxBits   = 4;
  localparam int CntBits   = 5;
  localparam int CoordBits = 16;
  localparam int SizeBits  = 13;

  typedef enum logic [2:0] {
    REQ_CREATE   = 3'd0,
    REQ_MOVE_ABS = 3'd1,
    REQ_MOVE_REL = 3'd2,
    REQ_SET_HGT  = 3'd3,
    REQ_HIDE     = 3'd4,
    REQ_HIT      = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT,
    S_SCAN,
    S_DONE
  } state_t;

  // per-cell shift control
  typedef struct packed {
    logic take_upper;
    logic take_lower;
    logic load;
  } cell_ctrl_t;

endpackage

@@ design/lzht_cell.sv @@
// one stack entry of the z-order chain
`timescale 1ns / 1ps
module lzht_cell (
  input  logic                          clk,
  input  lzht_pkg::cell_ctrl_t          ctrl,
  input  logic [lzht_pkg::IdxBits-1:0]  upper_i,
  input  logic [lzht_pkg::IdxBits-1:0]  lower_i,
  input  logic [lzht_pkg::IdxBits-1:0]  load_val,
  output logic [lzht_pkg::IdxBits-1:0]  slot_o
);

  logic [lzht_pkg::IdxBits-1:0] slot_r;
  logic [lzht_pkg::IdxBits-1:0] slot_nxt;

  // pick the neighbour or the new entry
  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.load) begin
      slot_nxt = load_val;
    end else if (ctrl.take_upper) begin
      slot_nxt = upper_i;
    end else if (ctrl.take_lower) begin
      slot_nxt = lower_i;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_o = slot_r;

endmodule

@@ design/layer_zorder_hit_test_unit.sv @@
// top level: layer table, stack chain and request sequencer
//
// Keeps up to 16 layers and a bottom-to-top stack of visible layers.
// Input channel in_valid/in_ready carries one request transaction; the
// result channel out_valid/out_ready returns exactly one result transaction
// (result id and status) for each request. One request is worked on at a time.
// Create, moves, hide, unused codes and unknown ids pass from the execute state
// to the done state, which loads the result into the output register and raises
// out_valid; the next request is taken once the unit is idle again.
// A set height that places the layer in the stack adds an insert state.
// A hit test walks the stack chain from the top, one entry per cycle, and ends
// at the first hit or, when nothing is hit, in a closing step with no entries left.
// The stack itself is a chain of cells that shift an entry up or down by
// one place per insert or remove, all cells in the same cycle.
// Reset (rst_n low at a clock edge) empties the stack and the layer count;
// layer data is undefined until written.
// While the receiver holds out_ready low the result stays in the output
// register; the block still takes one further request, finishes it and then
// holds in_ready low until the output register is free.
`timescale 1ns / 1ps
module layer_zorder_hit_test_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_req_type,
  input  logic [4:0]          in_layer_id,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic signed [5:0]   in_new_height,
  input  logic [12:0]         in_win_width,
  input  logic [12:0]         in_win_height,
  input  logic                in_win_present,
  input  logic [4:0]          in_exclude_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          out_result_id,
  output logic [1:0]          out_status
);

  localparam int N  = lzht_pkg::MaxLayers;
  localparam int IB = lzht_pkg::IdxBits;
  localparam int CB = lzht_pkg::CntBits;
  localparam int XB = lzht_pkg::CoordBits;
  localparam int SB = lzht_pkg::SizeBits;

  lzht_pkg::state_t state_r, state_nxt;

  // request registers
  logic [2:0]          req_r;
  logic [4:0]          id_r;
  logic signed [15:0]  px_r, py_r;
  logic signed [5:0]   hgt_r;
  logic [12:0]         ww_r, wh_r;
  logic                wp_r;
  logic [4:0]          ex_r;

  logic [CB-1:0] count_r, count_nxt;
  logic [CB-1:0] next_id_r, next_id_nxt;
  logic [CB-1:0] ins_pos_r, ins_pos_nxt;
  logic [CB-1:0] scan_r, scan_nxt;
  logic [4:0]    res_r, res_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [4:0]    out_id_r;
  logic [1:0]    out_st_r;
  logic          out_valid_r;

  // layer table
  logic signed [XB-1:0] lx_r [N];
  logic signed [XB-1:0] ly_r [N];
  logic [SB-1:0]        lw_r [N];
  logic [SB-1:0]        lh_r [N];
  logic                 lwin_r [N];

  logic [IB-1:0] slot [N];
  lzht_pkg::cell_ctrl_t ctrl [N];

  logic                 known;
  logic [IB-1:0]        idx;
  logic [N-1:0]         match;
  logic                 found;
  logic [IB-1:0]        cur_pos;
  logic [IB-1:0]        scan_idx;
  logic [IB-1:0]        li;
  logic [IB-1:0]        rd_addr;
  logic signed [XB+2:0] rx, ry, qx, qy, rxe, rye;
  logic                 hit;
  logic [CB-1:0]        hc;
  logic                 do_remove;
  logic                 do_insert;
  logic                 wr_pos;
  logic                 wr_rel;
  logic                 wr_new;
  logic [IB-1:0]        wr_addr;
  logic                 fin;
  logic                 accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == lzht_pkg::S_IDLE);
  assign fin      = (!out_valid_r || out_ready);

  // id lookup
  assign known = (id_r != 5'd0) && (id_r <= next_id_r);
  assign idx   = IB'(id_r - 5'd1);

  // find the entry of the target layer in the stack
  always_comb begin
    cur_pos = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = (slot[i] == idx) && (CB'(i) < count_r);
      if (match[i]) cur_pos = IB'(i);
    end
  end
  assign found = |match;

  // scan read: top-most remaining entry
  assign scan_idx = IB'(scan_r - CB'(1));
  assign li       = slot[scan_idx];
  assign rd_addr  = (state_r == lzht_pkg::S_SCAN) ? li : idx;

  // rectangle test on the scanned layer
  always_comb begin
    rx  = (XB+3)'(lx_r[rd_addr]);
    ry  = (XB+3)'(ly_r[rd_addr]);
    rxe = rx + (XB+3)'({1'b0, lw_r[rd_addr]});
    rye = ry + (XB+3)'({1'b0, lh_r[rd_addr]});
    qx  = (XB+3)'(px_r);
    qy  = (XB+3)'(py_r);
    hit = lwin_r[rd_addr] && ({1'b0, li} + 5'd1 != ex_r) &&
          (rx <= qx) && (qx < rxe) && (ry <= qy) && (qy < rye);
  end

  // clamped height
  always_comb begin
    hc = (hgt_r[4:0] > count_r) ? count_r : hgt_r[4:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzht_pkg::S_IDLE: begin
        if (accept) state_nxt = lzht_pkg::S_EXEC;
      end
      lzht_pkg::S_EXEC: begin
        if (req_r == lzht_pkg::REQ_HIT) begin
          state_nxt = lzht_pkg::S_SCAN;
        end else if (do_insert) begin
          state_nxt = lzht_pkg::S_INSERT;
        end else begin
          state_nxt = lzht_pkg::S_DONE;
        end
      end
      lzht_pkg::S_INSERT: state_nxt = lzht_pkg::S_DONE;
      lzht_pkg::S_SCAN: begin
        if (scan_r == '0 || hit) state_nxt = lzht_pkg::S_DONE;
      end
      lzht_pkg::S_DONE: begin
        if (fin) state_nxt = lzht_pkg::S_IDLE;
      end
      default: state_nxt = lzht_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    ins_pos_nxt = ins_pos_r;
    scan_nxt    = scan_r;
    res_nxt     = res_r;
    st_nxt      = st_r;
    do_remove   = 1'b0;
    do_insert   = 1'b0;
    wr_pos      = 1'b0;
    wr_rel      = 1'b0;
    wr_new      = 1'b0;
    wr_addr     = idx;
    case (state_r)
      lzht_pkg::S_IDLE: begin
        res_nxt = '0;
        st_nxt  = lzht_pkg::STS_OK;
      end
      lzht_pkg::S_EXEC: begin
        case (req_r)
          lzht_pkg::REQ_CREATE: begin
            if (next_id_r >= CB'(N)) begin
              st_nxt = lzht_pkg::STS_FULL;
            end else begin
              wr_new      = 1'b1;
              wr_addr     = IB'(next_id_r);
              next_id_nxt = next_id_r + CB'(1);
              res_nxt     = next_id_r + CB'(1);
            end
          end
          lzht_pkg::REQ_MOVE_ABS, lzht_pkg::REQ_MOVE_REL,
          lzht_pkg::REQ_SET_HGT, lzht_pkg::REQ_HIDE: begin
            if (!known) begin
              st_nxt = lzht_pkg::STS_UNKNOWN;
            end else if (req_r == lzht_pkg::REQ_MOVE_ABS) begin
              wr_pos = 1'b1;
            end else if (req_r == lzht_pkg::REQ_MOVE_REL) begin
              wr_rel = 1'b1;
            end else if (req_r == lzht_pkg::REQ_HIDE || hgt_r < 0) begin
              if (found) begin
                do_remove = 1'b1;
                count_nxt = count_r - CB'(1);
              end
            end else if (found) begin
              do_remove   = 1'b1;
              count_nxt   = count_r - CB'(1);
              do_insert   = 1'b1;
              ins_pos_nxt = (hc >= count_r) ? count_r - CB'(1) : hc;
            end else if (count_r < CB'(N)) begin
              do_insert   = 1'b1;
              ins_pos_nxt = hc;
            end
          end
          lzht_pkg::REQ_HIT: scan_nxt = count_r;
          default: ;
        endcase
      end
      lzht_pkg::S_INSERT: count_nxt = count_r + CB'(1);
      lzht_pkg::S_SCAN: begin
        if (scan_r != '0) begin
          if (hit) res_nxt = {1'b0, li} + 5'd1;
          scan_nxt = scan_r - CB'(1);
        end
      end
      default: ;
    endcase
  end

  // per-cell shift controls
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctrl[i].take_upper = do_remove && (IB'(i) >= cur_pos);
      ctrl[i].take_lower = (state_r == lzht_pkg::S_INSERT) && (CB'(i) > ins_pos_r);
      ctrl[i].load       = (state_r == lzht_pkg::S_INSERT) && (CB'(i) == ins_pos_r);
    end
  end

  // stack chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    lzht_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .upper_i  ((g == N-1) ? IB'(0) : slot[(g+1) % N]),
      .lower_i  ((g == 0) ? IB'(0) : slot[(g+N-1) % N]),
      .load_val (idx),
      .slot_o   (slot[g])
    );
  end

  // layer table writes
  always_ff @(posedge clk) begin
    if (wr_new) begin
      lx_r[wr_addr]   <= px_r;
      ly_r[wr_addr]   <= py_r;
      lw_r[wr_addr]   <= ww_r;
      lh_r[wr_addr]   <= wh_r;
      lwin_r[wr_addr] <= wp_r;
    end else if (wr_pos) begin
      lx_r[wr_addr] <= px_r;
      ly_r[wr_addr] <= py_r;
    end else if (wr_rel) begin
      lx_r[wr_addr] <= lx_r[rd_addr] + px_r;
      ly_r[wr_addr] <= ly_r[rd_addr] + py_r;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      id_r  <= in_layer_id;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      hgt_r <= in_new_height;
      ww_r  <= in_win_width;
      wh_r  <= in_win_height;
      wp_r  <= in_win_present;
      ex_r  <= in_exclude_id;
    end
    ins_pos_r <= ins_pos_nxt;
    scan_r    <= scan_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    if (state_r == lzht_pkg::S_DONE && fin) begin
      out_id_r <= res_r;
      out_st_r <= st_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzht_pkg::S_IDLE;
      count_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      if (state_r == lzht_pkg::S_DONE && fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_st_r;

endmodule

@@ sim/tb_layer_zorder_hit_test_unit.sv @@
// testbench for the layer z-order hit test unit: directed and random requests
`timescale 1ns / 1ps
module tb_layer_zorder_hit_test_unit;

  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic [4:0] in_layer_id = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [5:0] in_new_height = '0;
  logic [12:0] in_win_width = '0;
  logic [12:0] in_win_height = '0;
  logic in_win_present = 1'b0;
  logic [4:0] in_exclude_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_result_id;
  logic [1:0] out_status;

  layer_zorder_hit_test_unit u_top (.*);

  // shadow copy of the layer table and stack
  logic signed [15:0] sh_x [lzht_pkg::MaxLayers];
  logic signed [15:0] sh_y [lzht_pkg::MaxLayers];
  logic [12:0] sh_w [lzht_pkg::MaxLayers];
  logic [12:0] sh_h [lzht_pkg::MaxLayers];
  logic sh_win [lzht_pkg::MaxLayers];
  int sh_stack [lzht_pkg::MaxLayers];
  int sh_count = 0;
  int sh_created = 0;

  typedef struct packed {
    logic [4:0] id;
    logic [1:0] st;
  } answer_t;
  answer_t pending_answers [$];

  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  initial forever #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int find_slot(int idx);
    for (int i = 0; i < sh_count; i++) if (sh_stack[i] == idx) return i;
    return sh_count;
  endfunction

  function automatic void drop_slot(int p);
    if (p >= sh_count) return;
    for (int i = p; i + 1 < sh_count; i++) sh_stack[i] = sh_stack[i + 1];
    sh_count--;
  endfunction

  function automatic void put_slot(int p, int idx);
    if (sh_count >= lzht_pkg::MaxLayers) return;
    if (p > sh_count) p = sh_count;
    for (int i = sh_count; i > p; i--) sh_stack[i] = sh_stack[i - 1];
    sh_stack[p] = idx;
    sh_count++;
  endfunction

  // predicted answer for one request, updating the shadow state
  function automatic answer_t predict_answer(logic [2:0] rq, logic [4:0] id,
      logic signed [15:0] px, logic signed [15:0] py, logic signed [5:0] hg,
      logic [12:0] ww, logic [12:0] wh, logic wp, logic [4:0] ex);
    answer_t a;
    int idx, cur, h, li;
    bit known;
    a = '0;
    known = id >= 1 && id <= sh_created;
    idx = known ? int'(id) - 1 : 0;
    case (rq)
      lzht_pkg::REQ_CREATE: begin
        if (sh_created >= lzht_pkg::MaxLayers) a.st = lzht_pkg::STS_FULL;
        else begin
          idx = sh_created;
          sh_created++;
          sh_x[idx] = px; sh_y[idx] = py;
          sh_w[idx] = ww; sh_h[idx] = wh; sh_win[idx] = wp;
          a.id = 5'(sh_created);
        end
      end
      lzht_pkg::REQ_MOVE_ABS, lzht_pkg::REQ_MOVE_REL, lzht_pkg::REQ_SET_HGT,
      lzht_pkg::REQ_HIDE: begin
        if (!known) a.st = lzht_pkg::STS_UNKNOWN;
        else if (rq == lzht_pkg::REQ_MOVE_ABS) begin
          sh_x[idx] = px; sh_y[idx] = py;
        end else if (rq == lzht_pkg::REQ_MOVE_REL) begin
          sh_x[idx] = sh_x[idx] + px; sh_y[idx] = sh_y[idx] + py;
        end else begin
          cur = find_slot(idx);
          if (rq == lzht_pkg::REQ_HIDE || hg < 0) drop_slot(cur);
          else begin
            h = int'(hg);
            if (h > sh_count) h = sh_count;
            if (cur >= sh_count) put_slot(h, idx);
            else begin
              if (h >= sh_count) h = sh_count - 1;
              drop_slot(cur);
              put_slot(h, idx);
            end
          end
        end
      end
      lzht_pkg::REQ_HIT: begin
        for (int i = sh_count - 1; i >= 0; i--) begin
          li = sh_stack[i];
          if (li + 1 == int'(ex) || !sh_win[li]) continue;
          if (int'(sh_x[li]) <= int'(px) && int'(px) < int'(sh_x[li]) + int'(sh_w[li]) &&
              int'(sh_y[li]) <= int'(py) && int'(py) < int'(sh_y[li]) + int'(sh_h[li])) begin
            a.id = 5'(li + 1);
            break;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // send one request transaction and record its expected answer
  task automatic send_request(logic [2:0] rq, logic [4:0] id, logic signed [15:0] px,
      logic signed [15:0] py, logic signed [5:0] hg, logic [12:0] ww,
      logic [12:0] wh, logic wp, logic [4:0] ex);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq; in_layer_id <= id; in_pos_x <= px; in_pos_y <= py;
    in_new_height <= hg; in_win_width <= ww; in_win_height <= wh;
    in_win_present <= wp; in_exclude_id <= ex;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(predict_answer(rq, id, px, py, hg, ww, wh, wp, ex));
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: result_id %0d status %0d", out_result_id, out_status);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (out_result_id !== e.id) begin
          $error("result_id: expected %0d, actual %0d", e.id, out_result_id);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // random point, biased towards small coordinates near layers
  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic logic [4:0] rand_id();
    if ($urandom_range(0, 9) == 0) return 5'($urandom);
    return 5'($urandom_range(1, sh_created > 0 ? sh_created : 1));
  endfunction

  task automatic test_directed();
    send_request(lzht_pkg::REQ_MOVE_ABS, 5'd1, 0, 0, 0, 0, 0, 0, 0);  // unknown id
    send_request(lzht_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0, 0, 0);         // empty stack
    send_request(lzht_pkg::REQ_CREATE, 0, 16'sh7ff0, 16'sh7ff0, 0, 13'h1fff, 13'h1fff, 1, 0);
    send_request(lzht_pkg::REQ_CREATE, 0, -10, -10, 0, 20, 20, 1, 0);
    send_request(lzht_pkg::REQ_CREATE, 0, 0, 0, 0, 0, 5, 1, 0);       // zero width
    send_request(lzht_pkg::REQ_CREATE, 0, 0, 0, 0, 100, 100, 0, 0);   // no window
    send_request(lzht_pkg::REQ_SET_HGT, 5'd1, 0, 0, 6'sd31, 0, 0, 0, 0);   // clamp
    send_request(lzht_pkg::REQ_SET_HGT, 5'd2, 0, 0, 6'sd0, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_SET_HGT, 5'd3, 0, 0, 6'sd5, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_SET_HGT, 5'd4, 0, 0, 6'sd1, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_SET_HGT, 5'd2, 0, 0, 6'sd9, 0, 0, 0, 0);    // move in stack
    send_request(lzht_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_HIT, 0, 0, 0, 0, 0, 0, 0, 5'd2);            // excluded
    send_request(lzht_pkg::REQ_HIT, 0, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_MOVE_REL, 5'd1, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0); // wrap
    send_request(lzht_pkg::REQ_HIT, 0, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 5'd31);
    send_request(lzht_pkg::REQ_SET_HGT, 5'd1, 0, 0, -6'sd32, 0, 0, 0, 0);  // negative hides
    send_request(lzht_pkg::REQ_HIDE, 5'd1, 0, 0, 0, 0, 0, 0, 0);           // already hidden
    send_request(lzht_pkg::REQ_HIDE, 5'd4, 0, 0, 0, 0, 0, 0, 0);
    send_request(3'd6, 5'd2, 0, 0, 0, 0, 0, 0, 0);
    send_request(3'd7, 5'd0, 0, 0, 0, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_HIDE, 5'd0, 0, 0, 0, 0, 0, 0, 0);
    send_request(lzht_pkg::REQ_MOVE_REL, 5'd31, 0, 0, 0, 0, 0, 0, 0);
  endtask

  // random requests; fills the table so the full case shows up
  task automatic test_random(int n);
    logic [2:0] rq;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1: rq = lzht_pkg::REQ_CREATE;
        2, 3: rq = lzht_pkg::REQ_MOVE_ABS;
        4, 5: rq = lzht_pkg::REQ_MOVE_REL;
        6, 7, 8, 9, 10: rq = lzht_pkg::REQ_SET_HGT;
        11, 12: rq = lzht_pkg::REQ_HIDE;
        13: rq = 3'($urandom_range(6, 7));
        default: rq = lzht_pkg::REQ_HIT;
      endcase
      send_request(rq, rand_id(), rand_coord(), rand_coord(),
                   6'($signed($urandom_range(0, 19)) - 2) | ($urandom_range(0, 15) == 0 ?
                   6'($urandom) : 6'd0),
                   $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 300)),
                   $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 300)),
                   $urandom_range(0, 4) != 0,
                   $urandom_range(0, 1) ? 5'd0 : 5'($urandom));
    end
  endtask

  // receiver holds off while requests keep coming, then sender pauses
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(10);
    join
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_random(800);
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
